>>> src/mhdt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhdt_pkg
// Shared types and codes for the deadline timer queue.
// ---------------------------------------------------------------------------
package mhdt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ID_SPACE_DEF = 1024;
    localparam int ID_W         = 10;
    localparam int TMO_W        = 24;
    localparam int DL_W         = 32;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_ADJUST = 3'd2;
    localparam logic [2:0] OP_FIRE   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [TMO_W-1:0] REM_MAX = '1;

    // a strictly earlier than b, wrap-safe
    function automatic logic is_before(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
        logic [DL_W-1:0] d;
        d = a - b;
        return d[DL_W-1];
    endfunction

endpackage
`default_nettype wire

>>> src/min_heap_deadline_timer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// min_heap_deadline_timer
// Binary min-heap timer queue with id-to-slot map and millisecond counter.
// ---------------------------------------------------------------------------
// Usage:
//  One operation beat enters on the s_axis side (opcode, id, timeout). Each
//  operation returns zero or more expired/fired beats on m_axis followed by
//  one done beat with tlast high and a status in tuser.
//  Heap ids and deadlines live in one synchronous memory of CAPACITY words,
//  the slot map in a second memory of ID_SPACE words; both have registered
//  reads. An id counts as active when its mapped slot is below the entry
//  count and holds that id, so clear only zeroes the count.
//  Throughput: one operation at a time. A sift-down level does two child
//  reads, a compare and two writes for the swap; a sift-up level reads the
//  parent, compares and does two writes for the swap. A tick or query pops
//  each expired root with one emit and one sift-down walk.
//  Reset: the queue is empty, time is zero; a clearing pass then writes
//  every slot-map word while s_axis_tready is low.
//  Stall: while m_axis_tready is low the sequencer holds in its emit state
//  and s_axis_tready stays low; nothing is lost.
// ---------------------------------------------------------------------------
module min_heap_deadline_timer
    import mhdt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_SPACE = ID_SPACE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // opcode[2:0] timer_id[12:3] timeout_ms[36:13]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // kind[1:0] out_id[11:2] remaining_ms[35:12]
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    output logic             m_axis_tlast    // last
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
    localparam int EW = ID_W + DL_W;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_MAPRD, S_MAPWT, S_CHK,
        S_EMIT, S_POPRD, S_POPWT, S_POPCHK,
        S_RMLAST, S_RMLASTWT, S_RMPUT,
        S_DN_RD, S_DN_L, S_DN_R, S_DN_DEC,
        S_UP_RD, S_UP_P, S_UP_DEC,
        S_SWAP1, S_SWAP2, S_MAPW2, S_DONE
    } t_state;

    // heap entry memory {id, deadline}
    logic [EW-1:0] heap_mem [CAPACITY];
    logic [SW-1:0] slot_mem [ID_SPACE];

    logic          hp_we;
    logic [SW-1:0] hp_wa, hp_ra;
    logic [EW-1:0] hp_wd, r_hp_rd;
    logic          sm_we;
    logic [IW-1:0] sm_wa, sm_ra;
    logic [SW-1:0] sm_wd, r_sm_rd;

    always_ff @(posedge i_clk) begin
        if (hp_we) heap_mem[hp_wa] <= hp_wd;
        r_hp_rd <= heap_mem[hp_ra];
        if (sm_we) slot_mem[sm_wa] <= sm_wd;
        r_sm_rd <= slot_mem[sm_ra];
    end

    t_state          r_state, r_ret;
    logic [2:0]      r_op;
    logic [ID_W-1:0] r_id;
    logic [DL_W-1:0] r_now, r_dl;
    logic [CW-1:0]   r_cnt;
    logic [SW-1:0]   r_i, r_c;
    logic [EW-1:0]   r_cur, r_ch;      // node entry, chosen child/parent entry
    logic            r_haveR, r_moved;
    logic [1:0]      r_kind, r_st;
    logic [ID_W-1:0] r_oid;
    logic [TMO_W-1:0] r_rem;
    logic            r_last;
    logic            r_known;
    logic [IW-1:0]   r_clr;            // slot-map clearing pass address

    logic [ID_W-1:0] in_id;
    logic [CW:0]     l_idx;
    logic [DL_W-1:0] dd;
    assign in_id = s_axis_tdata[12:3];
    assign l_idx = (CW+1)'({r_i, 1'b1});

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign m_axis_tdata  = {4'd0, r_rem, r_oid, r_kind};
    assign m_axis_tuser  = r_st;
    assign m_axis_tlast  = r_last;
    assign dd = r_hp_rd[DL_W-1:0] - r_now;

    // after a sift: pop loops return to root check; others finish
    function automatic t_state S_DONE2();
        return (r_op == OP_TICK || r_op == OP_QUERY) ? S_POPRD : S_DONE;
    endfunction

    // memory ports driven by state
    always_comb begin
        hp_we = 1'b0; hp_wa = r_i; hp_wd = r_cur; hp_ra = r_i;
        sm_we = 1'b0; sm_wa = r_id[IW-1:0]; sm_wd = r_i; sm_ra = r_id[IW-1:0];
        case (r_state)
            S_INIT: begin
                sm_we = 1'b1; sm_wa = r_clr; sm_wd = '0;
            end
            S_MAPRD:  hp_ra = r_sm_rd;
            S_POPRD, S_POPWT: hp_ra = '0;
            S_RMLAST: hp_ra = SW'(r_cnt - CW'(1));
            S_RMLASTWT: hp_ra = SW'(r_cnt);
            S_RMPUT: begin
                hp_we = 1'b1; hp_wd = r_hp_rd;
                sm_we = 1'b1; sm_wa = r_hp_rd[EW-1 -: ID_W][IW-1:0];
            end
            S_DN_RD:  hp_ra = SW'(l_idx);
            S_DN_L:   hp_ra = SW'(l_idx + 1);
            S_UP_RD:  hp_ra = SW'((r_i - SW'(1)) >> 1);
            S_UP_P:   hp_ra = r_c;
            S_SWAP1: begin
                hp_we = 1'b1; hp_wa = r_i; hp_wd = r_ch;
                sm_we = 1'b1; sm_wa = r_ch[EW-1 -: ID_W][IW-1:0]; sm_wd = r_i;
            end
            S_SWAP2: begin
                hp_we = 1'b1; hp_wa = r_c; hp_wd = r_cur;
                sm_we = 1'b1; sm_wa = r_cur[EW-1 -: ID_W][IW-1:0]; sm_wd = r_c;
            end
            S_MAPW2: begin
                hp_we = 1'b1; hp_wa = r_i; hp_wd = r_cur;
                sm_we = 1'b1; sm_wa = r_cur[EW-1 -: ID_W][IW-1:0]; sm_wd = r_i;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ret    <= S_IDLE;
            r_cnt    <= '0;
            r_now    <= '0;
            r_clr    <= '0;
            r_last   <= 1'b0;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (r_clr == IW'(ID_SPACE - 1)) r_state <= S_IDLE;
                    else r_clr <= r_clr + IW'(1);
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_op    <= s_axis_tdata[2:0];
                    r_id    <= in_id;
                    r_dl    <= r_now + DL_W'(s_axis_tdata[36:13]);
                    r_st    <= ST_OK;
                    r_rem   <= '0;
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    case (r_op)
                        OP_TICK: begin
                            r_now <= r_now + DL_W'(1);
                            r_state <= S_POPRD;
                        end
                        OP_QUERY: r_state <= S_POPRD;
                        OP_CLEAR: begin
                            r_cnt <= '0; r_state <= S_DONE;
                        end
                        OP_SET, OP_ADJUST, OP_FIRE: r_state <= S_MAPRD;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MAPRD: r_state <= S_MAPWT;
                // live id: mapped slot is in use and holds this id
                S_MAPWT: begin
                    r_known <= (32'(r_id) < ID_SPACE) && (CW'(r_sm_rd) < r_cnt) &&
                               (r_hp_rd[EW-1 -: ID_W] == r_id);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_op == OP_FIRE) begin
                        if (r_cnt == '0) begin
                            r_st <= ST_EMPTY; r_state <= S_DONE;
                        end else if (!r_known) begin
                            r_st <= ST_UNKNOWN; r_state <= S_DONE;
                        end else begin
                            r_i <= r_sm_rd;
                            r_kind <= KIND_FIRED; r_oid <= r_id; r_last <= 1'b0;
                            r_ret <= S_RMLAST; r_state <= S_EMIT;
                        end
                    end else if (r_known) begin
                        r_i <= r_sm_rd;
                        r_cur <= {r_id, r_dl};
                        r_moved <= 1'b0;
                        r_state <= S_MAPW2;
                    end else if (r_op == OP_ADJUST || 32'(r_id) >= ID_SPACE) begin
                        r_st <= ST_UNKNOWN; r_state <= S_DONE;
                    end else if (32'(r_cnt) >= CAPACITY) begin
                        r_st <= ST_FULL; r_state <= S_DONE;
                    end else begin
                        r_i <= SW'(r_cnt);
                        r_cur <= {r_id, r_dl};
                        r_cnt <= r_cnt + CW'(1);
                        r_moved <= 1'b1;   // new entry: only sift up
                        r_state <= S_MAPW2;
                    end
                end
                S_MAPW2: r_state <= r_moved ? S_UP_RD : S_DN_RD;
                S_EMIT: if (m_axis_tready) begin
                    r_state <= r_last ? S_IDLE : r_ret;
                end
                S_POPRD: r_state <= S_POPWT;
                S_POPWT: r_state <= S_POPCHK;
                S_POPCHK: begin
                    if (r_cnt != '0 && (dd == '0 || dd[DL_W-1])) begin
                        r_i <= '0;
                        r_kind <= KIND_EXPIRED; r_oid <= r_hp_rd[EW-1 -: ID_W];
                        r_last <= 1'b0; r_ret <= S_RMLAST; r_state <= S_EMIT;
                    end else if (r_op == OP_QUERY) begin
                        if (r_cnt == '0) r_st <= ST_EMPTY;
                        else r_rem <= dd[DL_W-1] ? '0 :
                                      (|dd[DL_W-1:TMO_W]) ? REM_MAX : dd[TMO_W-1:0];
                        r_state <= S_DONE;
                    end else r_state <= S_DONE;
                end
                // remove slot r_i: move last entry in, then sift
                S_RMLAST: begin
                    r_cnt <= r_cnt - CW'(1);
                    r_state <= S_RMLASTWT;
                end
                S_RMLASTWT: begin
                    if (CW'(r_i) < r_cnt) r_state <= S_RMPUT;
                    else r_state <= (r_op == OP_FIRE) ? S_DONE : S_POPRD;
                end
                S_RMPUT: begin
                    r_cur <= r_hp_rd; r_moved <= 1'b0; r_state <= S_DN_RD;
                end
                // sift-down: r_cur holds entry at r_i
                S_DN_RD: begin
                    if (l_idx >= (CW+1)'(r_cnt)) r_state <= r_moved ? S_DONE2() : S_UP_RD;
                    else begin
                        r_haveR <= (l_idx + 1) < (CW+1)'(r_cnt);
                        r_state <= S_DN_L;
                    end
                end
                S_DN_L: begin
                    r_ch <= r_hp_rd; r_c <= SW'(l_idx); r_state <= S_DN_R;
                end
                S_DN_R: begin
                    if (r_haveR && is_before(r_hp_rd[DL_W-1:0], r_ch[DL_W-1:0])) begin
                        r_ch <= r_hp_rd; r_c <= SW'(l_idx + 1);
                    end
                    r_state <= S_DN_DEC;
                end
                S_DN_DEC: begin
                    if (is_before(r_ch[DL_W-1:0], r_cur[DL_W-1:0])) begin
                        r_moved <= 1'b1; r_ret <= S_DN_RD; r_state <= S_SWAP1;
                    end else r_state <= r_moved ? S_DONE2() : S_UP_RD;
                end
                // sift-up
                S_UP_RD: begin
                    if (r_i == '0) r_state <= S_DONE2();
                    else begin
                        r_c <= SW'((r_i - SW'(1)) >> 1); r_state <= S_UP_P;
                    end
                end
                S_UP_P: r_state <= S_UP_DEC;
                S_UP_DEC: begin
                    r_ch <= r_hp_rd;
                    if (is_before(r_cur[DL_W-1:0], r_hp_rd[DL_W-1:0])) begin
                        r_ret <= S_UP_RD; r_state <= S_SWAP1;
                    end else r_state <= S_DONE2();
                end
                S_SWAP1: r_state <= S_SWAP2;
                S_SWAP2: begin
                    r_i <= r_c; r_state <= r_ret;
                end
                S_DONE: begin
                    r_kind <= KIND_DONE; r_oid <= '0; r_last <= 1'b1;
                    r_state <= S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CAPACITY) else $error("entry count over capacity");
    a_rdy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("accept while emitting");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == KIND_DONE)
        else $error("last on non-done beat");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_DISPATCH && $past(r_op) == OP_CLEAR |-> r_cnt == '0)
        else $error("clear left entries");

endmodule
`default_nettype wire
